FILE: sv/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared constants, types and helper functions for the HSL to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

  // fixed point: 16 fraction bits, 1.0 needs a 17th bit
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned FX_W   = FRAC_W + 1;
  // q, p and their difference
  localparam int unsigned QP_W   = FX_W + 1;
  // ramp multiplicand (6*t or 2/3-t)
  localparam int unsigned M_W    = 16;
  localparam int unsigned PROD_W = QP_W + M_W;
  // ramp value before channel scaling
  localparam int unsigned V_W    = QP_W + 3;
  localparam int unsigned CH_W   = 8;

  // pipeline depth
  localparam int unsigned NSTG   = 6;
  localparam int unsigned NCH    = 3;

  localparam logic [FX_W-1:0] FRAC_ONE        = FX_W'(65536);
  localparam logic [FX_W-1:0] FRAC_HALF       = FX_W'(32768);
  localparam logic [FX_W-1:0] FRAC_THIRD      = FX_W'(21845);
  localparam logic [FX_W-1:0] FRAC_SIXTH      = FX_W'(10922);
  localparam logic [FX_W-1:0] FRAC_TWO_THIRDS = FX_W'(43690);

  // channel index
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // piece of the hue ramp
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_FLAT = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_t;

  // n/255 in 16-bit fraction: n*257 plus one extra lsb at n = 255
  function automatic logic [FX_W-1:0] to_fixed(input logic [7:0] n);
    logic [FX_W-1:0] base;
    base = {1'b0, n, n};
    return base + {{(FX_W-1){1'b0}}, (n == 8'hFF)};
  endfunction

  // pick the ramp piece for a wrapped hue position
  function automatic seg_t seg_of(input logic [FX_W-1:0] t);
    seg_t s;
    if (t < FRAC_SIXTH) begin
      s = SEG_RISE;
    end else if (t < FRAC_HALF) begin
      s = SEG_FLAT;
    end else if (t < FRAC_TWO_THIRDS) begin
      s = SEG_FALL;
    end else begin
      s = SEG_LOW;
    end
    return s;
  endfunction

  // floor(v*255/65536), clamped to 255
  function automatic logic [CH_W-1:0] to_channel(input logic [V_W-1:0] v);
    logic [V_W+7:0] w;
    logic [V_W-9:0] c;
    w = {v, 8'b0} - {8'b0, v};
    c = w[V_W+7:FRAC_W];
    return (c > (V_W-8)'(255)) ? 8'hFF : c[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Pipelined HSL to RGB pixel converter with alpha pass-through.
// ----------------------------------------------------------------------------
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+-----------------
//   input   | in_hue, in_saturation, in_lightness,         | in_valid/in_ready
//           | in_alpha_in                                  |
//   result  | out_red, out_green, out_blue, out_alpha_out  | out_valid/out_ready
//
// One pixel per clock sustained while out_ready is not held low; the result
// passes through six register stages (expand, l*s multiply and hue wrap,
// q/p/segment, ramp multiply, ramp sum, channel scale).
// Each stage holds its own valid bit and advances when the next one is free,
// so bubbles collapse and a stalled output still lets the pipe fill.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none

module hsl_to_rgb_converter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_hue,
  input  wire logic [7:0] in_saturation,
  input  wire logic [7:0] in_lightness,
  input  wire logic [7:0] in_alpha_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha_out
);

  localparam int unsigned FX_W   = hsl_pkg::FX_W;
  localparam int unsigned QP_W   = hsl_pkg::QP_W;
  localparam int unsigned M_W    = hsl_pkg::M_W;
  localparam int unsigned PROD_W = hsl_pkg::PROD_W;
  localparam int unsigned V_W    = hsl_pkg::V_W;
  localparam int unsigned CH_W   = hsl_pkg::CH_W;
  localparam int unsigned FRAC_W = hsl_pkg::FRAC_W;
  localparam int unsigned NSTG   = hsl_pkg::NSTG;
  localparam int unsigned NCH    = hsl_pkg::NCH;

  // stage valid bits and advance enables
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  // stage a: expanded inputs
  logic [FX_W-1:0] h_a_r, s_a_r, l_a_r;
  logic [FX_W-1:0] h_a_nxt, s_a_nxt, l_a_nxt;
  logic [7:0]      alpha_a_r, alpha_a_nxt;

  // stage b: l*s and wrapped hue positions
  logic [QP_W-1:0] ls_b_r, ls_b_nxt;
  logic [FX_W-1:0] l_b_r, s_b_r, l_b_nxt, s_b_nxt;
  logic [FX_W-1:0] t_b_r   [NCH];
  logic [FX_W-1:0] t_b_nxt [NCH];
  logic [7:0]      alpha_b_r, alpha_b_nxt;

  // stage c: q, p, difference, segment and multiplicand
  logic [QP_W-1:0]   q_c_r, p_c_r, d_c_r;
  logic [QP_W-1:0]   q_c_nxt, p_c_nxt, d_c_nxt;
  hsl_pkg::seg_t     seg_c_r   [NCH];
  hsl_pkg::seg_t     seg_c_nxt [NCH];
  logic [M_W-1:0]    m_c_r     [NCH];
  logic [M_W-1:0]    m_c_nxt   [NCH];
  logic [7:0]        alpha_c_r, alpha_c_nxt;

  // stage d: ramp products
  logic [PROD_W-1:0] prod_d_r   [NCH];
  logic [PROD_W-1:0] prod_d_nxt [NCH];
  logic [QP_W-1:0]   q_d_r, p_d_r;
  hsl_pkg::seg_t     seg_d_r    [NCH];
  logic [7:0]        alpha_d_r;

  // stage e: ramp values
  logic [V_W-1:0]    v_e_r   [NCH];
  logic [V_W-1:0]    v_e_nxt [NCH];
  logic [7:0]        alpha_e_r;

  // stage f: output register
  logic [CH_W-1:0]   ch_f_r   [NCH];
  logic [CH_W-1:0]   ch_f_nxt [NCH];
  logic [7:0]        alpha_f_r;

  // ready chain: a stage moves when empty or when the next one moves
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_comb begin
    vld_nxt[0] = in_valid;
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // stage a: n/255 expansion
  always_comb begin
    h_a_nxt     = hsl_pkg::to_fixed(in_hue);
    s_a_nxt     = hsl_pkg::to_fixed(in_saturation);
    l_a_nxt     = hsl_pkg::to_fixed(in_lightness);
    alpha_a_nxt = in_alpha_in;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      h_a_r     <= h_a_nxt;
      s_a_r     <= s_a_nxt;
      l_a_r     <= l_a_nxt;
      alpha_a_r <= alpha_a_nxt;
    end
  end

  // stage b: l*s product and hue offsets with wrap
  always_comb begin
    logic [2*FX_W-1:0] ls_full;
    logic [FX_W-1:0]   t_up;
    ls_full  = (2*FX_W)'(l_a_r) * (2*FX_W)'(s_a_r);
    ls_b_nxt = ls_full[FRAC_W+QP_W-1:FRAC_W];
    t_up     = h_a_r + hsl_pkg::FRAC_THIRD;
    t_b_nxt[hsl_pkg::CH_RED]   = (t_up > hsl_pkg::FRAC_ONE) ? t_up - hsl_pkg::FRAC_ONE : t_up;
    t_b_nxt[hsl_pkg::CH_GREEN] = h_a_r;
    t_b_nxt[hsl_pkg::CH_BLUE]  = (h_a_r < hsl_pkg::FRAC_THIRD) ?
                                 h_a_r + hsl_pkg::FRAC_ONE - hsl_pkg::FRAC_THIRD :
                                 h_a_r - hsl_pkg::FRAC_THIRD;
    l_b_nxt     = l_a_r;
    s_b_nxt     = s_a_r;
    alpha_b_nxt = alpha_a_r;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ls_b_r    <= ls_b_nxt;
      l_b_r     <= l_b_nxt;
      s_b_r     <= s_b_nxt;
      t_b_r     <= t_b_nxt;
      alpha_b_r <= alpha_b_nxt;
    end
  end

  // stage c: q, p with clamp, ramp piece and multiplicand
  always_comb begin
    logic [QP_W-1:0] two_l;
    logic [QP_W-1:0] l_w;
    logic [QP_W-1:0] s_w;
    l_w   = QP_W'(l_b_r);
    s_w   = QP_W'(s_b_r);
    two_l = {l_b_r, 1'b0};
    q_c_nxt = (l_b_r < hsl_pkg::FRAC_HALF) ? l_w + ls_b_r : l_w + s_w - ls_b_r;
    p_c_nxt = (two_l >= q_c_nxt) ? two_l - q_c_nxt : '0;
    d_c_nxt = (q_c_nxt >= p_c_nxt) ? q_c_nxt - p_c_nxt : '0;
    for (int c = 0; c < NCH; c++) begin
      seg_c_nxt[c] = hsl_pkg::seg_of(t_b_r[c]);
      case (seg_c_nxt[c])
        hsl_pkg::SEG_RISE: m_c_nxt[c] = M_W'((t_b_r[c] << 2) + (t_b_r[c] << 1));
        hsl_pkg::SEG_FALL: m_c_nxt[c] = M_W'(hsl_pkg::FRAC_TWO_THIRDS - t_b_r[c]);
        default:           m_c_nxt[c] = '0;
      endcase
    end
    alpha_c_nxt = alpha_b_r;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      q_c_r     <= q_c_nxt;
      p_c_r     <= p_c_nxt;
      d_c_r     <= d_c_nxt;
      seg_c_r   <= seg_c_nxt;
      m_c_r     <= m_c_nxt;
      alpha_c_r <= alpha_c_nxt;
    end
  end

  // stage d: one multiplier per channel
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod_d_nxt[c] = PROD_W'(d_c_r) * PROD_W'(m_c_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      prod_d_r  <= prod_d_nxt;
      q_d_r     <= q_c_r;
      p_d_r     <= p_c_r;
      seg_d_r   <= seg_c_r;
      alpha_d_r <= alpha_c_r;
    end
  end

  // stage e: truncate product and assemble ramp value
  always_comb begin
    logic [V_W-1:0] x;
    for (int c = 0; c < NCH; c++) begin
      x = V_W'(prod_d_r[c][PROD_W-1:FRAC_W]);
      case (seg_d_r[c])
        hsl_pkg::SEG_RISE: v_e_nxt[c] = V_W'(p_d_r) + x;
        hsl_pkg::SEG_FLAT: v_e_nxt[c] = V_W'(q_d_r);
        hsl_pkg::SEG_FALL: v_e_nxt[c] = V_W'(p_d_r) + (x << 2) + (x << 1);
        default:           v_e_nxt[c] = V_W'(p_d_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      v_e_r     <= v_e_nxt;
      alpha_e_r <= alpha_d_r;
    end
  end

  // stage f: scale to 8-bit channels
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ch_f_nxt[c] = hsl_pkg::to_channel(v_e_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ch_f_r    <= ch_f_nxt;
      alpha_f_r <= alpha_e_r;
    end
  end

  assign out_valid     = vld_r[NSTG-1];
  assign out_red       = ch_f_r[hsl_pkg::CH_RED];
  assign out_green     = ch_f_r[hsl_pkg::CH_GREEN];
  assign out_blue      = ch_f_r[hsl_pkg::CH_BLUE];
  assign out_alpha_out = alpha_f_r;

`ifndef SYNTH
  // input is refused only when every stage holds a pixel
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input blocked while pipeline has a free stage");

  // zero saturation collapses q and p, so no ramp slope
  a_gray_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && adv[2] && s_b_r == '0) |=> (d_c_r == '0))
    else $error("nonzero q-p for zero saturation");

  // a held middle stage keeps its pixel
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && !adv[3]) |=> (vld_r[3] && $stable(prod_d_r[0])))
    else $error("stalled ramp product lost");

  // the flat piece passes q straight through
  a_flat_is_q: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && adv[4] && seg_d_r[0] == hsl_pkg::SEG_FLAT) |=>
      (v_e_r[0] == V_W'($past(q_d_r))))
    else $error("flat ramp value differs from q");
`endif

endmodule

`default_nettype wire
